// ===== sv/acfr_pkg.sv =====
`default_nettype none
package acfr_pkg;

   localparam int REPLAY_DEPTH = 8;
   localparam int HEAD_W = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;

   localparam logic [31:0] PRELUDE_SEED = 32'h5A5A5A5A;
   localparam logic [31:0] PRELUDE_STEP = 32'h9E3779B9;
   localparam logic [31:0] ABSORB_MUL   = 32'h5BD1E995;
   localparam logic [31:0] FINISH_MUL1  = 32'h85EBCA6B;
   localparam logic [31:0] FINISH_MUL2  = 32'hC2B2AE35;
   localparam logic [15:0] WRAP_HIGH    = 16'hFF00;
   localparam logic [15:0] WRAP_LOW     = 16'h0100;
   localparam logic [8:0]  FRAME_EXTRA  = 9'd10;
   localparam logic [8:0]  TAG_BYTES    = 9'd4;
   localparam logic [8:0]  HDR_BYTES    = 9'd6;

   localparam logic [7:0] MAC_KEY [32] = '{
      8'h48, 8'h4D, 8'h41, 8'h43, 8'h5F, 8'h47, 8'h4F, 8'h4C,
      8'h47, 8'h45, 8'h31, 8'h5F, 8'h53, 8'h45, 8'h43, 8'h52,
      8'h45, 8'h54, 8'h5F, 8'h4B, 8'h45, 8'h59, 8'h5F, 8'h32,
      8'h30, 8'h32, 8'h36, 8'h5F, 8'h54, 8'h55, 8'h41, 8'h21
   };

   function automatic logic [31:0] key_prelude();
      logic [31:0] h;
      h = PRELUDE_SEED;
      for (int i = 0; i < 32; i++) begin
         h = h ^ {24'd0, MAC_KEY[i]};
         h = {h[24:0], h[31:25]};
         h = h + PRELUDE_STEP;
      end
      return h;
   endfunction

   localparam logic [31:0] MAC_INIT = key_prelude();

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADTAG = 2'd1,
      STATUS_REPLAY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_SYNC1 = 2'd0,
      REG_SYNC2 = 2'd1,
      REG_MIN   = 2'd2,
      REG_MAX   = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_SYNC1, ST_SYNC2, ST_LEN, ST_LMUL, ST_LMIX, ST_BODY, ST_MUL, ST_MIX,
      ST_FIN2, ST_FIN3, ST_TAG, ST_EMIT_DATA, ST_EMIT_VERDICT
   } state_type;

   typedef struct packed {
      logic load_len;
      logic load_body;
      logic absorb_mul;
      logic absorb_mix;
      logic fin1;
      logic fin2;
      logic fin3;
      logic tag_cmp;
      logic emit_data;
      logic emit_verdict;
   } cmd_type;

   typedef struct packed {
      logic sync1_hit;
      logic sync2_hit;
      logic is_data;
      logic is_pend;
      logic is_hdr;
      logic is_last;
      logic range_ok;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

// ===== sv/acfr_ctrl.sv =====
`default_nettype none
module acfr_ctrl
   import acfr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type st,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_SYNC1: begin
            req_tready = 1'b1;
            if (req_tvalid && st.sync1_hit) state_in = ST_SYNC2;
         end
         ST_SYNC2: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = st.sync2_hit ? ST_LEN : ST_SYNC1;
         end
         ST_LEN: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_len = 1'b1;
               state_in     = ST_LMUL;
            end
         end
         ST_LMUL: begin
            cmd.absorb_mul = 1'b1;
            state_in       = ST_LMIX;
         end
         ST_LMIX: begin
            cmd.absorb_mix = 1'b1;
            state_in       = st.range_ok ? ST_BODY : ST_SYNC1;
         end
         ST_BODY: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_body = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            priority if (st.is_data) begin
               cmd.absorb_mul = 1'b1;
               state_in       = ST_MIX;
            end else if (st.is_pend) begin
               cmd.fin1 = 1'b1;
               state_in = ST_FIN2;
            end else begin
               state_in = ST_TAG;
            end
         end
         ST_MIX: begin
            cmd.absorb_mix = 1'b1;
            state_in       = st.is_hdr ? ST_BODY : ST_EMIT_DATA;
         end
         ST_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            cmd.fin3 = 1'b1;
            state_in = ST_TAG;
         end
         ST_TAG: begin
            cmd.tag_cmp = 1'b1;
            state_in    = st.is_last ? ST_EMIT_VERDICT : ST_BODY;
         end
         ST_EMIT_DATA: begin
            if (!st.rsp_busy) begin
               cmd.emit_data = 1'b1;
               state_in      = ST_BODY;
            end
         end
         ST_EMIT_VERDICT: begin
            if (!st.rsp_busy) begin
               cmd.emit_verdict = 1'b1;
               state_in         = ST_SYNC1;
            end
         end
         default: state_in = ST_SYNC1;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/acfr_datapath.sv =====
`default_nettype none
module acfr_datapath
   import acfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         st,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [7:0]  sync_byte_one,
   input  wire logic [7:0]  sync_byte_two,
   input  wire logic [8:0]  min_frame_length,
   input  wire logic [8:0]  max_frame_length,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tuser
);

   logic [7:0]  byte_ff;
   logic [8:0]  idx_ff, count_ff, flen_ff;
   logic [31:0] mac_ff, prod_ff;
   logic [15:0] seq_ff, highest_ff;
   logic [7:0]  cmd_ff, tdiff_ff;
   logic [15:0] seen_ff [REPLAY_DEPTH];
   logic [HEAD_W-1:0] head_ff;
   logic        rsp_valid_ff;
   logic        rsp_verdict_ff;
   logic [7:0]  rsp_data_ff, rsp_cmd_ff, rsp_plen_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_seq_ff;

   logic [8:0]  pend;
   logic [8:0]  tag_pos;
   logic [7:0]  expect_byte;
   logic [31:0] mix_in, fin1_t, fin2_t;
   logic [15:0] gap;
   logic        hit, reject;
   status_type  status;
   logic [7:0]  plen;

   assign pend    = flen_ff - TAG_BYTES;
   assign tag_pos = idx_ff - pend;
   assign plen    = 8'(flen_ff - FRAME_EXTRA);

   always_comb begin
      unique case (tag_pos[1:0])
         2'd0: expect_byte = mac_ff[31:24];
         2'd1: expect_byte = mac_ff[23:16];
         2'd2: expect_byte = mac_ff[15:8];
         default: expect_byte = mac_ff[7:0];
      endcase
   end

   assign mix_in = mac_ff ^ {24'd0, byte_ff};
   assign fin1_t = mac_ff ^ (mac_ff >> 16);
   assign fin2_t = prod_ff ^ (prod_ff >> 13);

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < REPLAY_DEPTH; i++) begin
         if (seen_ff[i] == seq_ff) hit = 1'b1;
      end
   end

   assign gap    = highest_ff - seq_ff;
   assign reject = ((seq_ff <= highest_ff) && (gap < 16'(REPLAY_DEPTH)) && hit) ||
                   ((seq_ff < highest_ff) && (gap >= 16'(REPLAY_DEPTH)) &&
                    !((highest_ff > WRAP_HIGH) && (seq_ff < WRAP_LOW)));

   always_comb begin
      priority if (tdiff_ff != 8'd0) status = STATUS_BADTAG;
      else if (reject)               status = STATUS_REPLAY;
      else                           status = STATUS_OK;
   end

   always_comb begin
      st.sync1_hit = (rx_byte == sync_byte_one);
      st.sync2_hit = (rx_byte == sync_byte_two);
      st.is_data   = (idx_ff < pend);
      st.is_pend   = (idx_ff == pend);
      st.is_hdr    = (idx_ff < HDR_BYTES);
      st.is_last   = (count_ff >= flen_ff);
      st.range_ok  = (flen_ff <= max_frame_length) && (flen_ff >= min_frame_length);
      st.rsp_busy  = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         count_ff   <= '0;
         flen_ff    <= '0;
         mac_ff     <= MAC_INIT;
         seq_ff     <= '0;
         cmd_ff     <= '0;
         tdiff_ff   <= '0;
         highest_ff <= '0;
         head_ff    <= '0;
         for (int i = 0; i < REPLAY_DEPTH; i++) seen_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_len) begin
            byte_ff  <= rx_byte;
            flen_ff  <= FRAME_EXTRA + {1'b0, rx_byte};
            idx_ff   <= 9'd2;
            count_ff <= 9'd3;
            mac_ff   <= MAC_INIT;
            tdiff_ff <= '0;
            seq_ff   <= '0;
            cmd_ff   <= '0;
         end
         if (cmd.load_body) begin
            byte_ff  <= rx_byte;
            idx_ff   <= count_ff;
            count_ff <= count_ff + 9'd1;
         end
         if (cmd.absorb_mul) begin
            prod_ff <= 32'({mix_in[18:0], mix_in[31:19]} * ABSORB_MUL);
         end
         if (cmd.absorb_mix) begin
            mac_ff <= prod_ff ^ (prod_ff >> 15);
            if (idx_ff == 9'd3) seq_ff[15:8] <= byte_ff;
            if (idx_ff == 9'd4) seq_ff[7:0]  <= byte_ff;
            if (idx_ff == 9'd5) cmd_ff       <= byte_ff;
         end
         if (cmd.fin1) prod_ff <= 32'(fin1_t * FINISH_MUL1);
         if (cmd.fin2) prod_ff <= 32'(fin2_t * FINISH_MUL2);
         if (cmd.fin3) mac_ff  <= prod_ff ^ (prod_ff >> 16);
         if (cmd.tag_cmp) tdiff_ff <= tdiff_ff | (expect_byte ^ byte_ff);
         if (cmd.emit_verdict && status == STATUS_OK) begin
            seen_ff[head_ff] <= seq_ff;
            head_ff <= (head_ff == HEAD_W'(REPLAY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            if (seq_ff > highest_ff) highest_ff <= seq_ff;
         end
         if (cmd.emit_data || cmd.emit_verdict) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_data || cmd.emit_verdict) begin
         rsp_verdict_ff <= cmd.emit_verdict;
         rsp_data_ff    <= cmd.emit_verdict ? 8'd0 : byte_ff;
         rsp_status_ff  <= cmd.emit_verdict ? status : STATUS_OK;
         rsp_seq_ff     <= seq_ff;
         rsp_cmd_ff     <= cmd_ff;
         rsp_plen_ff    <= plen;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_verdict_ff;
   assign rsp_tdata  = {6'd0, rsp_plen_ff, rsp_cmd_ff, rsp_seq_ff, rsp_status_ff, rsp_data_ff};

   a_emit_space: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_data || cmd.emit_verdict) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken beat");
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.emit_verdict |=> $stable(head_ff))
      else $error("replay window moved without a verdict");
   a_high_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.emit_verdict |=> $stable(highest_ff))
      else $error("highest sequence moved without a verdict");

endmodule
`default_nettype wire

// ===== sv/authenticated_command_frame_receiver.sv =====
`default_nettype none
// Receives a frame one byte per beat: two sync bytes, a length byte, sequence, command id,
// payload and a 4-byte big-endian tag. Payload bytes come out as pass-through beats
// (tuser low); the last tag byte gives one verdict beat (tuser high). The next byte is not
// taken until the last one is through: the length, header and payload bytes pass a multiply
// state and a mix state, a tag byte the tag compare (the first one after the finalizer's
// states), and a result waits while the previous beat is not taken. Frames whose total
// length falls outside the configured range are dropped silently.
module authenticated_command_frame_receiver
   import acfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // data_byte, frame_status, sequence_res,
                                         // command_id, payload_length
   output logic             rsp_tuser,   // is_verdict
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [7:0]  sync1_ff, sync2_ff;
   logic [8:0]  min_ff, max_ff;
   csr_idx_type csr_idx;
   cmd_type     cmd;
   stat_type    st;

   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync1_ff <= 8'd235;
         sync2_ff <= 8'd144;
         min_ff   <= 9'd10;
         max_ff   <= 9'd265;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_SYNC1: sync1_ff <= csr_pwdata[7:0];
            REG_SYNC2: sync2_ff <= csr_pwdata[7:0];
            REG_MIN:   min_ff   <= csr_pwdata[8:0];
            REG_MAX:   max_ff   <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SYNC1: csr_prdata = {24'd0, sync1_ff};
         REG_SYNC2: csr_prdata = {24'd0, sync2_ff};
         REG_MIN:   csr_prdata = {23'd0, min_ff};
         REG_MAX:   csr_prdata = {23'd0, max_ff};
         default:   csr_prdata = '0;
      endcase
   end

   acfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   acfr_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .rx_byte          (req_tdata),
      .sync_byte_one    (sync1_ff),
      .sync_byte_two    (sync2_ff),
      .min_frame_length (min_ff),
      .max_frame_length (max_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import acfr_pkg::*;

   typedef struct {
      logic       is_verdict;
      logic [7:0] data_byte;
      logic [1:0] frame_status;
      logic [15:0] sequence_res;
      logic [7:0] command_id;
      logic [7:0] payload_length;
   } frame_beat_type;

   typedef enum {HUNT_SYNC1, HUNT_SYNC2, HUNT_LEN, IN_FRAME} hunt_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   authenticated_command_frame_receiver dut (.*);

   // receiver copy of the block state
   logic [7:0]  cfg_sync1, cfg_sync2;
   logic [8:0]  cfg_min, cfg_max;
   hunt_type    phase;
   logic [8:0]  byte_cnt, frame_len;
   logic [31:0] mac_acc, mac_seed;
   logic [15:0] held_seq, top_seq;
   logic [7:0]  held_cmd, tag_diff;
   logic [15:0] seen_seq [REPLAY_DEPTH];
   logic [2:0]  seen_head;

   frame_beat_type expected_beats [$];
   int          errors = 0;
   bit          idle_on = 1;
   int          sent_bytes = 0;
   logic [15:0] next_seq;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("authenticated_command_frame_receiver: mismatch");
      $finish;
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] mac_mix(input logic [31:0] h, input logic [7:0] b);
      h = h ^ {24'd0, b};
      h = rol(h, 13);
      h = h * ABSORB_MUL;
      return h ^ (h >> 15);
   endfunction

   function automatic logic [31:0] mac_final(input logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * FINISH_MUL1;
      h = h ^ (h >> 13);
      h = h * FINISH_MUL2;
      return h ^ (h >> 16);
   endfunction

   function automatic bit window_accept(input logic [15:0] s);
      if (s <= top_seq && top_seq - s < REPLAY_DEPTH) begin
         for (int i = 0; i < REPLAY_DEPTH; i++)
            if (seen_seq[i] == s) return 0;
      end
      if (s < top_seq && top_seq - s >= REPLAY_DEPTH) begin
         if (!(top_seq > WRAP_HIGH && s < WRAP_LOW)) return 0;
      end
      seen_seq[seen_head] = s;
      seen_head = seen_head + 3'd1;
      if (s > top_seq) top_seq = s;
      return 1;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      logic [8:0]  total, idx, pend, plen9;
      logic [1:0]  k;
      logic [31:0] want;
      frame_beat_type r;
      case (phase)
         HUNT_SYNC2: begin
            if (b == cfg_sync2) begin
               byte_cnt = 2;
               phase = HUNT_LEN;
            end else phase = HUNT_SYNC1;
         end
         HUNT_LEN: begin
            total = FRAME_EXTRA + {1'b0, b};
            frame_len = total;
            byte_cnt = 3;
            mac_acc = mac_mix(mac_seed, b);
            tag_diff = 0;
            held_seq = 0;
            held_cmd = 0;
            phase = (total > cfg_max || total < cfg_min) ? HUNT_SYNC1 : IN_FRAME;
         end
         IN_FRAME: begin
            idx = byte_cnt;
            pend = frame_len - 9'd4;
            plen9 = frame_len - 9'd10;
            byte_cnt = byte_cnt + 9'd1;
            if (idx < pend) begin
               mac_acc = mac_mix(mac_acc, b);
               if (idx == 3) held_seq[15:8] = b;
               else if (idx == 4) held_seq[7:0] = b;
               else if (idx == 5) held_cmd = b;
               else begin
                  r = '{1'b0, b, STATUS_OK, held_seq, held_cmd, plen9[7:0]};
                  expected_beats.push_back(r);
               end
            end else begin
               if (idx == pend) mac_acc = mac_final(mac_acc);
               k = 2'(idx - pend);
               want = mac_acc >> (8 * (3 - k));
               tag_diff = tag_diff | (want[7:0] ^ b);
               if (byte_cnt >= frame_len) begin
                  phase = HUNT_SYNC1;
                  r = '{1'b1, 8'd0, STATUS_OK, held_seq, held_cmd, plen9[7:0]};
                  if (tag_diff != 0) r.frame_status = STATUS_BADTAG;
                  else if (!window_accept(held_seq)) r.frame_status = STATUS_REPLAY;
                  expected_beats.push_back(r);
               end
            end
         end
         default: begin
            if (b == cfg_sync1) begin
               byte_cnt = 1;
               phase = HUNT_SYNC2;
            end else phase = HUNT_SYNC1;
         end
      endcase
   endfunction

   // result side: random stalls
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      frame_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_tuser !== e.is_verdict) begin
               $error("is_verdict exp %0d got %0d", e.is_verdict, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] !== e.data_byte) begin
               $error("data_byte exp %0d got %0d", e.data_byte, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[9:8] !== e.frame_status) begin
               $error("frame_status exp %0d got %0d", e.frame_status, rsp_tdata[9:8]);
               errors++;
            end
            if (rsp_tdata[25:10] !== e.sequence_res) begin
               $error("sequence_res exp %0d got %0d", e.sequence_res, rsp_tdata[25:10]);
               errors++;
            end
            if (rsp_tdata[33:26] !== e.command_id) begin
               $error("command_id exp %0d got %0d", e.command_id, rsp_tdata[33:26]);
               errors++;
            end
            if (rsp_tdata[41:34] !== e.payload_length) begin
               $error("payload_length exp %0d got %0d", e.payload_length,
                      rsp_tdata[41:34]);
               errors++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      sent_bytes++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SYNC1: cfg_sync1 = v[7:0];
         REG_SYNC2: cfg_sync2 = v[7:0];
         REG_MIN:   cfg_min = v[8:0];
         default:   cfg_max = v[8:0];
      endcase
   endtask

   task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [8:0] lo, input logic [8:0] hi);
      drain();
      write_csr(REG_SYNC1, {24'd0, s1});
      write_csr(REG_SYNC2, {24'd0, s2});
      write_csr(REG_MIN, {23'd0, lo});
      write_csr(REG_MAX, {23'd0, hi});
   endtask

   // one frame with a correct tag unless bad_tag is set
   task automatic send_frame(input logic [7:0] len, input logic [15:0] s,
                             input logic [7:0] cmd, input bit bad_tag);
      logic [31:0] h;
      logic [7:0]  pb;
      h = mac_mix(mac_mix(mac_mix(mac_mix(mac_seed, len), s[15:8]), s[7:0]), cmd);
      send_byte(cfg_sync1);
      send_byte(cfg_sync2);
      send_byte(len);
      send_byte(s[15:8]);
      send_byte(s[7:0]);
      send_byte(cmd);
      for (int i = 0; i < len; i++) begin
         pb = 8'($urandom);
         h = mac_mix(h, pb);
         send_byte(pb);
      end
      h = mac_final(h);
      if (bad_tag) h = h ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 3; i >= 0; i--) send_byte(h[8*i +: 8]);
   endtask

   task automatic test_basic_frames();
      send_frame(8'd0, 16'd0, 8'h00, 0);       // seq 0 is in the reset window
      send_frame(8'd0, 16'd1, 8'hFF, 0);
      send_frame(8'd255, 16'd2, 8'hA5, 0);
      send_frame(8'd3, 16'd3, 8'h5A, 1);       // tag mismatch
      send_frame(8'd2, 16'd3, 8'h11, 0);
      send_frame(8'd1, 16'd3, 8'h22, 0);       // replay
      next_seq = 4;
   endtask

   task automatic test_sync_hunt();
      send_byte(cfg_sync1);
      send_byte(cfg_sync1);                    // not retried as first sync
      send_byte(cfg_sync2);
      send_byte(8'h00);
      send_byte(cfg_sync1);
      send_byte(8'h12);                        // wrong second sync
      send_frame(8'd4, next_seq, 8'h33, 0);
      next_seq++;
   endtask

   task automatic test_length_range();
      set_config(8'h00, 8'hFF, 9'd10, 9'd10);
      send_frame(8'd1, 16'd50, 8'h01, 0);      // dropped
      send_frame(8'd0, 16'd51, 8'h02, 0);
      set_config(8'hFF, 8'h00, 9'd20, 9'd20);
      send_frame(8'd9, 16'd52, 8'h03, 0);      // dropped
      send_frame(8'd10, 16'd53, 8'h04, 0);
      set_config(8'h55, 8'hAA, 9'd200, 9'd20); // min above max drops all
      send_frame(8'd5, 16'd54, 8'h05, 0);
      set_config(8'hEB, 8'h90, 9'd12, 9'd20);
      send_frame(8'd1, 16'd60, 8'h06, 0);
      send_frame(8'd2, 16'd61, 8'h07, 0);
      send_frame(8'd10, 16'd62, 8'h08, 0);
      send_frame(8'd11, 16'd63, 8'h09, 0);
      set_config(8'hEB, 8'h90, 9'd10, 9'd265);
   endtask

   task automatic test_window_wrap();
      send_frame(8'd0, 16'd40, 8'h10, 0);
      send_frame(8'd0, 16'd20, 8'h11, 0);      // stale
      send_frame(8'd0, 16'd37, 8'h12, 0);      // stale
      send_frame(8'd0, 16'hFF80, 8'h13, 0);
      send_frame(8'd0, 16'h0005, 8'h14, 0);    // wrap accepted
      send_frame(8'd0, 16'h0200, 8'h15, 0);    // stale, not low enough
      send_frame(8'd0, 16'hFFFF, 8'h16, 0);
      next_seq = 16'h0010;
   endtask

   task automatic test_random(input int stop_at);
      int  kind;
      logic [7:0] len;
      logic [15:0] s;
      while (sent_bytes < stop_at) begin
         if (sent_bytes > 640) idle_on = 0;
         kind = $urandom_range(0, 19);
         len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 60))
                                           : 8'($urandom_range(0, 6));
         s = next_seq;
         if (kind < 12) begin
            next_seq = next_seq + 16'($urandom_range(1, 3));
            send_frame(len, s, 8'($urandom), 0);
         end else if (kind < 14) begin
            send_frame(len, next_seq - 16'($urandom_range(0, 12)), 8'($urandom), 0);
         end else if (kind < 15) begin
            send_frame(len, next_seq, 8'($urandom), 1);
         end else if (kind < 17) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end else begin
            send_byte(cfg_sync1);
            send_byte($urandom_range(0, 1) ? cfg_sync2 : 8'($urandom));
            send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 8'd0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 4'd0;
      csr_pwdata  <= 32'd0;
      mac_seed = PRELUDE_SEED;
      for (int i = 0; i < 32; i++)
         mac_seed = rol(mac_seed ^ {24'd0, MAC_KEY[i]}, 7) + PRELUDE_STEP;
      cfg_sync1 = 8'hEB;
      cfg_sync2 = 8'h90;
      cfg_min = 9'd10;
      cfg_max = 9'd265;
      phase = HUNT_SYNC1;
      byte_cnt = 0;
      frame_len = 0;
      mac_acc = mac_seed;
      held_seq = 0;
      held_cmd = 0;
      tag_diff = 0;
      top_seq = 0;
      seen_head = 0;
      for (int i = 0; i < REPLAY_DEPTH; i++) seen_seq[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_frames();
      test_sync_hunt();
      test_length_range();
      test_window_wrap();
      test_random(620);
      set_config(8'($urandom), 8'($urandom), 9'(10 + $urandom_range(0, 8)), 9'd265);
      test_random(710);
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_beats.size() == 0)
         $display("authenticated_command_frame_receiver: match");
      else
         $display("authenticated_command_frame_receiver: mismatch");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/acfr_pkg.sv
sv/acfr_ctrl.sv
sv/acfr_datapath.sv
sv/authenticated_command_frame_receiver.sv
test/testbench.sv
